// ----- rtl/gvs_pkg.sv -----
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared types, codes and timer helpers for the gate valve sequencer.
// ----------------------------------------------------------------------------
package gvs_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

   typedef logic [TIMER_WIDTH-1:0] count_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_CONFIRM = 8'd0,
      CSR_EXIT_CONFIRM  = 8'd1,
      CSR_TRAVEL_TMO    = 8'd2,
      CSR_BLINK_HALF    = 8'd3
   } csr_idx_type;

   localparam cfg_type ENTRY_CONFIRM_RST = 16'd1000;
   localparam cfg_type EXIT_CONFIRM_RST  = 16'd2000;
   localparam cfg_type TRAVEL_TMO_RST    = 16'd10000;
   localparam cfg_type BLINK_HALF_RST    = 16'd100;

   // valve position codes
   localparam logic [1:0] POS_CLOSED = 2'd0;
   localparam logic [1:0] POS_OPEN   = 2'd1;

   typedef enum logic [1:0] {
      MOT_BRAKE = 2'd0,
      MOT_OPEN  = 2'd1,
      MOT_CLOSE = 2'd2
   } motor_type;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_STARTING = 8'b0000_0001,
      ST_CLOSING  = 8'b0000_0010,
      ST_CLOSED   = 8'b0000_0100,
      ST_ENTERING = 8'b0000_1000,
      ST_OPENING  = 8'b0001_0000,
      ST_OPEN     = 8'b0010_0000,
      ST_EXITING  = 8'b0100_0000,
      ST_ERROR    = 8'b1000_0000
   } state_type;

   // numeric state codes as reported
   localparam logic [2:0] SC_STARTING = 3'd0;
   localparam logic [2:0] SC_CLOSING  = 3'd1;
   localparam logic [2:0] SC_CLOSED   = 3'd2;
   localparam logic [2:0] SC_ENTERING = 3'd3;
   localparam logic [2:0] SC_OPENING  = 3'd4;
   localparam logic [2:0] SC_OPEN     = 3'd5;
   localparam logic [2:0] SC_EXITING  = 3'd6;
   localparam logic [2:0] SC_ERROR    = 3'd7;

   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_CLOSED        = 4'd1,
      EV_START_CLOSING = 4'd2,
      EV_TRAVEL_TMO    = 4'd3,
      EV_LOST_CLOSED   = 4'd4,
      EV_ENTERING      = 4'd5,
      EV_CONFIRMED     = 4'd6,
      EV_ENTRY_TMO     = 4'd7,
      EV_OPENED        = 4'd8,
      EV_LOST_OPEN     = 4'd9,
      EV_EXITING       = 4'd10,
      EV_PASSED        = 4'd11,
      EV_EXIT_TMO      = 4'd12,
      EV_ERROR         = 4'd13
   } event_type;

   typedef struct packed {
      logic      running;
      count_type count;
   } timer_type;

   typedef struct packed {
      logic [1:0] motor_drive;
      logic       red_led;
      logic       green_led;
      logic [2:0] control_state;
      logic [3:0] event_code;
   } rsp_type;

   // one tick of a running timer, saturating at all ones
   function automatic timer_type tmr_advance(timer_type t);
      timer_type r;
      r = t;
      if (t.running && (t.count != {TIMER_WIDTH{1'b1}})) begin
         r.count = t.count + count_type'(1);
      end
      return r;
   endfunction

   function automatic timer_type tmr_start();
      timer_type r;
      r.running = 1'b1;
      r.count   = '0;
      return r;
   endfunction

   function automatic logic tmr_expired(timer_type t, cfg_type dur);
      logic [CMP_WIDTH-1:0] c;
      logic [CMP_WIDTH-1:0] d;
      c = CMP_WIDTH'(t.count);
      d = CMP_WIDTH'(dur);
      return t.running && (c >= d);
   endfunction

   // state of a timer after it is read: a stopped timer starts, an expired one stops
   function automatic timer_type tmr_read(timer_type t, cfg_type dur);
      timer_type r;
      r = t;
      if (!t.running) begin
         r = tmr_start();
      end else if (tmr_expired(t, dur)) begin
         r.running = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [2:0] state_code(state_type s);
      logic [2:0] c;
      unique case (s)
         ST_STARTING: c = SC_STARTING;
         ST_CLOSING:  c = SC_CLOSING;
         ST_CLOSED:   c = SC_CLOSED;
         ST_ENTERING: c = SC_ENTERING;
         ST_OPENING:  c = SC_OPENING;
         ST_OPEN:     c = SC_OPEN;
         ST_EXITING:  c = SC_EXITING;
         default:     c = SC_ERROR;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/gvs_if.sv -----
// ----------------------------------------------------------------------------
// gvs channel interfaces
// Tick input, result and register write channels (valid/ready).
// ----------------------------------------------------------------------------
interface gvs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] valve_position;
   logic       entry_seen;
   logic       exit_seen;

   modport source (output valid, valve_position, entry_seen, exit_seen, input ready);
   modport sink   (input valid, valve_position, entry_seen, exit_seen, output ready);
endinterface

interface gvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] motor_drive;
   logic       red_led;
   logic       green_led;
   logic [2:0] control_state;
   logic [3:0] event_code;

   modport source (output valid, motor_drive, red_led, green_led, control_state,
                   event_code, input ready);
   modport sink   (input valid, motor_drive, red_led, green_led, control_state,
                   event_code, output ready);
endinterface

interface gvs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [gvs_pkg::CSR_IDX_W-1:0] index;
   logic [gvs_pkg::CFG_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gate_valve_sequencer_with_timeouts.sv -----
// ----------------------------------------------------------------------------
// gate_valve_sequencer_with_timeouts
// Eight-state gate valve sequencer with entry/exit/travel timeouts and a
// blinking red LED; one result item per tick item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | accepted when        | payload
//  ---------+-----+----------------------+------------------------------------
//  req_ch   | in  | valid & ready        | valve_position, entry_seen, exit_seen
//  rsp_ch   | out | valid & ready        | motor_drive, red_led, green_led,
//           |     |                      | control_state, event_code
//  csr_ch   | in  | valid (ready tied 1) | index, data (16-bit registers 0..3)
//
//  One tick item per cycle while req_ch.ready is high; its result is written to
//  the output register, or to the skid entry while the output register is held.
//  All sequencer and timer updates for a tick happen in the accepting cycle.
//  A two-entry result buffer (output register plus skid) lets a new tick be
//  taken while one result waits; req_ch.ready drops only when both are full.
//  Synchronous active-high reset: starting state, timers stopped, motor brake,
//  red LED off, error unreported, registers at their defaults, result buffer empty.
//
module gate_valve_sequencer_with_timeouts (
   input  logic         clock,
   input  logic         reset,
   gvs_req_if.sink      req_ch,
   gvs_rsp_if.source    rsp_ch,
   gvs_csr_if.sink      csr_ch
);

   // configuration registers
   gvs_pkg::cfg_type entry_cfg_ff, exit_cfg_ff, travel_cfg_ff, blink_cfg_ff;

   // sequencer state
   gvs_pkg::state_type  state_ff, state_in;
   gvs_pkg::timer_type  entry_tmr_ff, entry_tmr_in;
   gvs_pkg::timer_type  exit_tmr_ff, exit_tmr_in;
   gvs_pkg::timer_type  travel_tmr_ff, travel_tmr_in;
   gvs_pkg::timer_type  blink_tmr_ff, blink_tmr_in;
   gvs_pkg::motor_type  motor_ff, motor_in;
   logic                red_ff, red_in;
   logic                err_rep_ff, err_rep_in;
   gvs_pkg::event_type  ev;

   // result buffer
   gvs_pkg::rsp_type    out_ff, skid_ff, result;
   logic                out_vld_ff, skid_vld_ff;

   // advanced timers (start-of-tick count)
   gvs_pkg::timer_type  entry_adv, exit_adv, travel_adv, blink_adv;

   logic push, pop;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = ~skid_vld_ff;
   assign push = req_ch.valid & req_ch.ready;
   assign pop  = out_vld_ff & rsp_ch.ready;

   // ---------------------------------------------------------------------
   // register writes; unknown indexes are dropped
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_cfg_ff  <= gvs_pkg::ENTRY_CONFIRM_RST;
         exit_cfg_ff   <= gvs_pkg::EXIT_CONFIRM_RST;
         travel_cfg_ff <= gvs_pkg::TRAVEL_TMO_RST;
         blink_cfg_ff  <= gvs_pkg::BLINK_HALF_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            gvs_pkg::CSR_ENTRY_CONFIRM: entry_cfg_ff  <= csr_ch.data;
            gvs_pkg::CSR_EXIT_CONFIRM:  exit_cfg_ff   <= csr_ch.data;
            gvs_pkg::CSR_TRAVEL_TMO:    travel_cfg_ff <= csr_ch.data;
            gvs_pkg::CSR_BLINK_HALF:    blink_cfg_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // one tick of the sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      entry_adv  = gvs_pkg::tmr_advance(entry_tmr_ff);
      exit_adv   = gvs_pkg::tmr_advance(exit_tmr_ff);
      travel_adv = gvs_pkg::tmr_advance(travel_tmr_ff);
      blink_adv  = gvs_pkg::tmr_advance(blink_tmr_ff);

      state_in      = state_ff;
      entry_tmr_in  = entry_adv;
      exit_tmr_in   = exit_adv;
      travel_tmr_in = travel_adv;
      blink_tmr_in  = blink_adv;
      motor_in      = motor_ff;
      red_in        = red_ff;
      err_rep_in    = err_rep_ff;
      ev            = gvs_pkg::EV_NONE;

      unique case (state_ff)
         gvs_pkg::ST_STARTING: begin
            if (req_ch.valve_position == gvs_pkg::POS_CLOSED) begin
               state_in = gvs_pkg::ST_CLOSED;
               ev       = gvs_pkg::EV_CLOSED;
            end else begin
               travel_tmr_in = gvs_pkg::tmr_start();
               motor_in      = gvs_pkg::MOT_CLOSE;
               state_in      = gvs_pkg::ST_CLOSING;
               ev            = gvs_pkg::EV_START_CLOSING;
            end
         end
         gvs_pkg::ST_CLOSING: begin
            blink_tmr_in = gvs_pkg::tmr_read(blink_adv, blink_cfg_ff);
            if (gvs_pkg::tmr_expired(blink_adv, blink_cfg_ff)) red_in = ~red_ff;
            travel_tmr_in = gvs_pkg::tmr_read(travel_adv, travel_cfg_ff);
            // arrival beats a timeout in the same tick
            if (req_ch.valve_position == gvs_pkg::POS_CLOSED) begin
               motor_in = gvs_pkg::MOT_BRAKE;
               red_in   = 1'b0;
               state_in = gvs_pkg::ST_CLOSED;
               ev       = gvs_pkg::EV_CLOSED;
            end else if (gvs_pkg::tmr_expired(travel_adv, travel_cfg_ff)) begin
               motor_in = gvs_pkg::MOT_BRAKE;
               state_in = gvs_pkg::ST_ERROR;
               ev       = gvs_pkg::EV_TRAVEL_TMO;
            end
         end
         gvs_pkg::ST_CLOSED: begin
            if (req_ch.valve_position != gvs_pkg::POS_CLOSED) begin
               travel_tmr_in = gvs_pkg::tmr_start();
               motor_in      = gvs_pkg::MOT_CLOSE;
               state_in      = gvs_pkg::ST_CLOSING;
               ev            = gvs_pkg::EV_LOST_CLOSED;
            end else if (req_ch.entry_seen) begin
               entry_tmr_in = gvs_pkg::tmr_start();
               state_in     = gvs_pkg::ST_ENTERING;
               ev           = gvs_pkg::EV_ENTERING;
            end
         end
         gvs_pkg::ST_ENTERING: begin
            entry_tmr_in = gvs_pkg::tmr_read(entry_adv, entry_cfg_ff);
            if (gvs_pkg::tmr_expired(entry_adv, entry_cfg_ff)) begin
               if (req_ch.entry_seen) begin
                  travel_tmr_in = gvs_pkg::tmr_start();
                  motor_in      = gvs_pkg::MOT_OPEN;
                  state_in      = gvs_pkg::ST_OPENING;
                  ev            = gvs_pkg::EV_CONFIRMED;
               end else begin
                  red_in   = 1'b0;
                  state_in = gvs_pkg::ST_CLOSED;
                  ev       = gvs_pkg::EV_ENTRY_TMO;
               end
            end
         end
         gvs_pkg::ST_OPENING: begin
            blink_tmr_in = gvs_pkg::tmr_read(blink_adv, blink_cfg_ff);
            if (gvs_pkg::tmr_expired(blink_adv, blink_cfg_ff)) red_in = ~red_ff;
            travel_tmr_in = gvs_pkg::tmr_read(travel_adv, travel_cfg_ff);
            if (req_ch.valve_position == gvs_pkg::POS_OPEN) begin
               motor_in = gvs_pkg::MOT_BRAKE;
               red_in   = 1'b0;
               state_in = gvs_pkg::ST_OPEN;
               ev       = gvs_pkg::EV_OPENED;
            end else if (gvs_pkg::tmr_expired(travel_adv, travel_cfg_ff)) begin
               motor_in = gvs_pkg::MOT_BRAKE;
               state_in = gvs_pkg::ST_ERROR;
               ev       = gvs_pkg::EV_TRAVEL_TMO;
            end
         end
         gvs_pkg::ST_OPEN: begin
            if (req_ch.valve_position != gvs_pkg::POS_OPEN) begin
               travel_tmr_in = gvs_pkg::tmr_start();
               motor_in      = gvs_pkg::MOT_OPEN;
               state_in      = gvs_pkg::ST_OPENING;
               ev            = gvs_pkg::EV_LOST_OPEN;
            end else if (req_ch.exit_seen) begin
               exit_tmr_in = gvs_pkg::tmr_start();
               state_in    = gvs_pkg::ST_EXITING;
               ev          = gvs_pkg::EV_EXITING;
            end
         end
         gvs_pkg::ST_EXITING: begin
            exit_tmr_in = gvs_pkg::tmr_read(exit_adv, exit_cfg_ff);
            if (gvs_pkg::tmr_expired(exit_adv, exit_cfg_ff)) begin
               if (!req_ch.exit_seen) begin
                  travel_tmr_in = gvs_pkg::tmr_start();
                  motor_in      = gvs_pkg::MOT_CLOSE;
                  state_in      = gvs_pkg::ST_CLOSING;
                  ev            = gvs_pkg::EV_PASSED;
               end else begin
                  state_in = gvs_pkg::ST_ERROR;
                  ev       = gvs_pkg::EV_EXIT_TMO;
               end
            end
         end
         default: begin
            // error latches; report it once
            if (!err_rep_ff) begin
               err_rep_in = 1'b1;
               red_in     = 1'b1;
               ev         = gvs_pkg::EV_ERROR;
            end
         end
      endcase

      result.motor_drive   = motor_in;
      result.red_led       = red_in;
      result.green_led     = ~err_rep_in;
      result.control_state = gvs_pkg::state_code(state_in);
      result.event_code    = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gvs_pkg::ST_STARTING;
         entry_tmr_ff  <= '0;
         exit_tmr_ff   <= '0;
         travel_tmr_ff <= '0;
         blink_tmr_ff  <= '0;
         motor_ff      <= gvs_pkg::MOT_BRAKE;
         red_ff        <= 1'b0;
         err_rep_ff    <= 1'b0;
      end else if (push) begin
         state_ff      <= state_in;
         entry_tmr_ff  <= entry_tmr_in;
         exit_tmr_ff   <= exit_tmr_in;
         travel_tmr_ff <= travel_tmr_in;
         blink_tmr_ff  <= blink_tmr_in;
         motor_ff      <= motor_in;
         red_ff        <= red_in;
         err_rep_ff    <= err_rep_in;
      end
   end

   // ---------------------------------------------------------------------
   // result buffer: output register plus skid entry
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || pop) begin
         out_vld_ff <= push;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (!out_vld_ff || pop) begin
         if (push) out_ff <= result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.motor_drive   = out_ff.motor_drive;
   assign rsp_ch.red_led       = out_ff.red_led;
   assign rsp_ch.green_led     = out_ff.green_led;
   assign rsp_ch.control_state = out_ff.control_state;
   assign rsp_ch.event_code    = out_ff.event_code;

endmodule

// ----- rtl/gvs_checker.sv -----
// ----------------------------------------------------------------------------
// gvs_checker
// Port-level checks for the gate valve sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module gvs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] motor_drive,
   input logic       red_led,
   input logic       green_led,
   input logic [2:0] control_state,
   input logic [3:0] event_code
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(motor_drive) && $stable(red_led)
         && $stable(green_led) && $stable(control_state) && $stable(event_code))
      else $error("stalled result changed");

   // green off only once the error is reported, with red on
   a_green_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !green_led |-> red_led && (control_state == gvs_pkg::SC_ERROR))
      else $error("green off outside error");

   // error report comes in error state with green off
   a_err_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_code == gvs_pkg::EV_ERROR) |->
         !green_led && red_led && (control_state == gvs_pkg::SC_ERROR))
      else $error("error event inconsistent");

   // in error the motor is braked
   a_err_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (control_state == gvs_pkg::SC_ERROR) |-> motor_drive == gvs_pkg::MOT_BRAKE)
      else $error("motor driven in error");

   // no result right after reset
   a_rst_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gate_valve_sequencer_with_timeouts gvs_checker u_gvs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .motor_drive   (rsp_ch.motor_drive),
   .red_led       (rsp_ch.red_led),
   .green_led     (rsp_ch.green_led),
   .control_state (rsp_ch.control_state),
   .event_code    (rsp_ch.event_code)
);
